// File: sv/tseq_pkg.sv
// ----------------------------------------------------------------------------
// tseq_pkg
// shared types and constants for the tone sequencer and its arpeggio voice
// ----------------------------------------------------------------------------
package tseq_pkg;

    // fixed field widths
    localparam int ADDR_W   = 10;
    localparam int ADDR_SPAN = 1 << ADDR_W;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 11;
    localparam int WAIT_W   = 16;
    localparam int ARP_W    = 2;
    localparam int PCNT_W   = 3;

    // pitch list and command fetch window
    localparam int PITCH_SLOTS = 4;
    localparam int FETCH_BYTES = 6;
    localparam int FETCH_W     = 3;

    // reset values
    localparam logic [BYTE_W-1:0] RHYTHM_RESET = 8'd255;
    localparam logic [BYTE_W-1:0] PITCH_RESET  = 8'd255;
    localparam logic [BYTE_W-1:0] THRESH_RESET = 8'd96;
    localparam logic [LEN_W-1:0]  LEN_RESET    = 11'd1024;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // configuration register indexes
    localparam logic CFG_ARP_THRESHOLD = 1'b0;
    localparam logic CFG_SEQ_LENGTH    = 1'b1;

    // command codes
    localparam logic [BYTE_W-1:0] CMD_SLEEP     = 8'd0;
    localparam logic [BYTE_W-1:0] CMD_PITCH_MIN = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_TONE      = 8'd5;
    localparam logic [BYTE_W-1:0] CMD_VOICE     = 8'd6;
    localparam logic [BYTE_W-1:0] CMD_RHYTHM    = 8'd7;
    localparam logic [BYTE_W-1:0] CMD_REPEAT    = 8'd8;

    // control from the sequencer to the voice
    typedef struct packed {
        logic              step;
        logic              rewind;
        logic              on;
        logic [PCNT_W-1:0] count;
    } voice_ctl_t;

endpackage

// File: sv/tone_sequencer_arpeggiator.sv
// ----------------------------------------------------------------------------
// tone_sequencer_arpeggiator
// one music track: command byte store, sequencer and arpeggio voice
// ----------------------------------------------------------------------------
// flow: a tick with a pending wait goes from accept straight to the voice state,
//   a tick that runs a command first does six store reads through the single
//   read port, then passes the execute state and the voice state
// write items pass through the address reduction steps before the store write;
//   a new item is taken only while the block is idle
// reset: asynchronous, clears all control state; the store is undefined
//   until written; the receiver cannot stall, each word shows for one cycle
module tone_sequencer_arpeggiator
    import tseq_pkg::*;
#(
    parameter int SEQ_DEPTH   = 1024,
    parameter int MAX_PITCHES = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    // command side
    input  logic              start,
    output logic              busy,
    input  logic              opcode,
    input  logic [ADDR_W-1:0] address,
    input  logic [BYTE_W-1:0] data,
    // configuration write port
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [LEN_W-1:0]  cfg_data,
    // result words
    output logic              valid,
    output logic [BYTE_W-1:0] pitch,
    output logic [BYTE_W-1:0] tone
);

    // store index width and a wide working width for position math
    localparam int AW = $clog2(SEQ_DEPTH);
    localparam int PW = ((AW > LEN_W) ? AW : LEN_W) + 2;
    // write addresses wider than the store are folded by shifted subtracts
    localparam int RED_STEPS = (SEQ_DEPTH >= ADDR_SPAN) ? 0
                             : $clog2(ADDR_SPAN / SEQ_DEPTH + 1);
    localparam int RED_W = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WRED  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_EXEC  = 5'b01000,
        ST_VOICE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // command store: one write or one read per cycle, registered read data
    logic [BYTE_W-1:0] mem [SEQ_DEPTH];
    logic [BYTE_W-1:0] mem_q;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_wa;
    logic [AW-1:0]     mem_ra;

    // write item holding registers
    logic [ADDR_W-1:0] addr_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [RED_W-1:0]  red_reg;

    // sequencer state
    logic [AW-1:0]     read_pos_reg;
    logic [AW-1:0]     jump_reg;
    logic [WAIT_W-1:0] wait_reg;
    logic [BYTE_W-1:0] rhythm_reg;
    logic [BYTE_W-1:0] pitch_reg [PITCH_SLOTS];
    logic [PCNT_W-1:0] pcount_reg;
    logic [BYTE_W-1:0] tone_reg;
    logic              von_reg;

    // configuration
    logic [BYTE_W-1:0] thr_reg;
    logic [LEN_W-1:0]  len_reg;

    // fetched command window
    logic [FETCH_W-1:0] cnt_reg;
    logic [BYTE_W-1:0]  buf_reg [FETCH_BYTES];

    // result word
    logic              valid_reg;
    logic [BYTE_W-1:0] pitch_out_reg;
    logic [BYTE_W-1:0] tone_out_reg;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // ------------------------------------------------------------------
    // position wrap before a command read
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] limit;
    logic [AW-1:0]    pos_wrapped;
    assign limit       = (len_reg == '0) ? '0 : len_reg - 11'd1;
    assign pos_wrapped = (PW'(read_pos_reg) >= PW'(limit)) ? '0 : read_pos_reg;

    // ------------------------------------------------------------------
    // write address reduction step
    // ------------------------------------------------------------------
    logic [PW-1:0]    addr_ext;
    logic [PW-1:0]    red_cmp;
    logic [RED_W-1:0] red_sh;
    assign addr_ext = PW'(addr_reg);
    assign red_sh   = red_reg - RED_W'(1);
    assign red_cmp  = PW'(SEQ_DEPTH) << red_sh;

    // ------------------------------------------------------------------
    // store port control
    // ------------------------------------------------------------------
    logic [PW-1:0] ra_sum;
    assign ra_sum = PW'(read_pos_reg) + PW'(cnt_reg);
    assign mem_ra = (ra_sum >= PW'(SEQ_DEPTH)) ? AW'(ra_sum - PW'(SEQ_DEPTH))
                                               : AW'(ra_sum);
    assign mem_re = (state_reg == ST_FETCH) && (cnt_reg < FETCH_W'(FETCH_BYTES));
    assign mem_we = (state_reg == ST_WRED) && (red_reg == '0);
    assign mem_wa = AW'(addr_ext);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= data_reg;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_ra];
        end
    end

    // ------------------------------------------------------------------
    // command decode on the fetched window
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]  code;
    logic [BYTE_W-1:0]  arg;
    logic               is_pitch;
    logic [FETCH_W-1:0] wsel;
    logic [WAIT_W-1:0]  wait_prod;
    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      adv;
    logic               take_jump;
    logic [PW-1:0]      step_sum;
    logic [PW-1:0]      jump_tgt;
    logic [AW-1:0]      pos_new;

    assign code     = buf_reg[0];
    assign arg      = buf_reg[1];
    assign is_pitch = (code >= CMD_PITCH_MIN) && (code <= BYTE_W'(MAX_PITCHES));
    // sleep byte sits right after the last pitch (right after the code for sleep)
    assign wsel      = FETCH_W'(code[FETCH_W-1:0]) + FETCH_W'(1);
    assign wait_prod = WAIT_W'(buf_reg[wsel]) * WAIT_W'(rhythm_reg);
    assign pos_ext   = PW'(read_pos_reg);

    always_comb
    begin
        adv       = '0;
        take_jump = 1'b0;
        case (code)
            CMD_SLEEP, CMD_TONE, CMD_VOICE, CMD_RHYTHM:
            begin
                adv = PW'(2);
            end
            CMD_REPEAT:
            begin
                if (jump_reg == read_pos_reg)
                begin
                    adv = PW'(2);
                end
                else
                begin
                    take_jump = 1'b1;
                end
            end
            default:
            begin
                // pitch codes advance past their bytes, anything else stalls
                if (is_pitch)
                begin
                    adv = PW'(code) + PW'(2);
                end
            end
        endcase
    end

    assign step_sum = pos_ext + adv;
    assign jump_tgt = (PW'(arg) > pos_ext) ? '0 : pos_ext - PW'(arg);
    assign pos_new  = take_jump ? AW'(jump_tgt)
                    : (step_sum >= PW'(SEQ_DEPTH)) ? AW'(step_sum - PW'(SEQ_DEPTH))
                    : AW'(step_sum);

    // ------------------------------------------------------------------
    // voice
    // ------------------------------------------------------------------
    voice_ctl_t       vctl;
    logic [ARP_W-1:0] vsel;
    logic             vfire;

    assign vctl.step   = (state_reg == ST_VOICE);
    assign vctl.rewind = (state_reg == ST_EXEC) && is_pitch;
    assign vctl.on     = von_reg;
    assign vctl.count  = pcount_reg;

    tseq_voice u_voice (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (vctl),
        .threshold (thr_reg),
        .sel       (vsel),
        .fire      (vfire)
    );

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_WRITE)
                    begin
                        state_next = ST_WRED;
                    end
                    else if (wait_reg != '0)
                    begin
                        state_next = ST_VOICE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_WRED:
            begin
                if (red_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                if (cnt_reg == FETCH_W'(FETCH_BYTES))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_VOICE;
            end
            ST_VOICE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            red_reg      <= '0;
            cnt_reg      <= '0;
            read_pos_reg <= '0;
            jump_reg     <= '0;
            wait_reg     <= '0;
            rhythm_reg   <= RHYTHM_RESET;
            pcount_reg   <= '0;
            tone_reg     <= '0;
            von_reg      <= 1'b0;
            thr_reg      <= THRESH_RESET;
            len_reg      <= LEN_RESET;
            valid_reg    <= 1'b0;
            for (int i = 0; i < PITCH_SLOTS; i++)
            begin
                pitch_reg[i] <= PITCH_RESET;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= vfire;

            // the user must write configuration only while idle; the block does not enforce it
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ARP_THRESHOLD: thr_reg <= cfg_data[BYTE_W-1:0];
                    CFG_SEQ_LENGTH:    len_reg <= cfg_data;
                    default:           len_reg <= cfg_data;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        red_reg <= RED_W'(RED_STEPS);
                        cnt_reg <= '0;
                        if (opcode == OP_TICK)
                        begin
                            if (wait_reg != '0)
                            begin
                                wait_reg <= wait_reg - 16'd1;
                            end
                            else
                            begin
                                read_pos_reg <= pos_wrapped;
                            end
                        end
                    end
                end
                ST_WRED:
                begin
                    if (red_reg != '0)
                    begin
                        red_reg <= red_sh;
                    end
                end
                ST_FETCH:
                begin
                    cnt_reg <= cnt_reg + FETCH_W'(1);
                end
                ST_EXEC:
                begin
                    read_pos_reg <= pos_new;
                    case (code)
                        CMD_SLEEP:
                        begin
                            wait_reg <= wait_prod;
                        end
                        CMD_TONE:
                        begin
                            tone_reg <= arg;
                        end
                        CMD_VOICE:
                        begin
                            von_reg <= (arg != '0);
                        end
                        CMD_RHYTHM:
                        begin
                            rhythm_reg <= arg;
                        end
                        CMD_REPEAT:
                        begin
                            jump_reg <= take_jump ? read_pos_reg : '0;
                        end
                        default:
                        begin
                            if (is_pitch)
                            begin
                                wait_reg   <= wait_prod;
                                pcount_reg <= PCNT_W'(code);
                                for (int i = 0; i < PITCH_SLOTS; i++)
                                begin
                                    if (BYTE_W'(i) < code)
                                    begin
                                        pitch_reg[i] <= buf_reg[i + 1];
                                    end
                                end
                            end
                        end
                    endcase
                end
                ST_VOICE:
                begin
                    cnt_reg <= '0;
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= address;
            data_reg <= data;
        end
        else if ((state_reg == ST_WRED) && (red_reg != '0) && (addr_ext >= red_cmp))
        begin
            addr_reg <= ADDR_W'(addr_ext - red_cmp);
        end

        // read data lands in the cycle after its address
        if ((state_reg == ST_FETCH) && (cnt_reg != '0))
        begin
            buf_reg[cnt_reg - FETCH_W'(1)] <= mem_q;
        end

        if (vfire)
        begin
            pitch_out_reg <= pitch_reg[vsel];
            tone_out_reg  <= tone_reg;
        end
    end

    assign valid = valid_reg;
    assign pitch = pitch_out_reg;
    assign tone  = tone_out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_word_after_voice: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(state_reg == ST_VOICE))
        else $error("result word without a voice cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_exec_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $past(state_reg == ST_FETCH))
        else $error("execute entered without a full fetch");

    a_pitch_count: assert property (@(posedge clk) disable iff (!rst_n)
        PCNT_W'(pcount_reg) <= PCNT_W'(MAX_PITCHES))
        else $error("pitch count above limit");

endmodule

// File: sv/tseq_voice.sv
// ----------------------------------------------------------------------------
// tseq_voice
// arpeggio stepper: picks the current pitch slot and advances it every
// threshold ticks while the voice is on and holds pitches
// ----------------------------------------------------------------------------
module tseq_voice
    import tseq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  voice_ctl_t        ctl,
    input  logic [BYTE_W-1:0] threshold,
    output logic [ARP_W-1:0]  sel,
    output logic              fire
);

    logic [ARP_W-1:0]  idx_reg;
    logic [ARP_W-1:0]  idx_next;
    logic [BYTE_W-1:0] ticks_reg;
    logic [BYTE_W-1:0] ticks_next;
    logic [BYTE_W-1:0] ticks_inc;
    logic [PCNT_W-1:0] idx_inc;

    // index past the count falls back to the first pitch
    assign sel       = (PCNT_W'(idx_reg) >= ctl.count) ? '0 : idx_reg;
    assign fire      = ctl.step && ctl.on && (ctl.count != '0);
    assign ticks_inc = ticks_reg + 8'd1;
    assign idx_inc   = PCNT_W'(sel) + 3'd1;

    always_comb
    begin
        idx_next   = idx_reg;
        ticks_next = ticks_reg;
        if (ctl.rewind)
        begin
            idx_next = '0;
        end
        else if (fire)
        begin
            if (ticks_inc >= threshold)
            begin
                ticks_next = '0;
                idx_next   = (idx_inc < ctl.count) ? ARP_W'(idx_inc) : '0;
            end
            else
            begin
                ticks_next = ticks_inc;
                idx_next   = sel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            ticks_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

// File: tb/sv/tone_sequencer_arpeggiator_test.sv
// ----------------------------------------------------------------------------
// tone_sequencer_arpeggiator_test
// self-checking bench for one sequencer track and its arpeggio voice: fills
// the command store, walks a short directed script, then plays random but
// well-formed tunes under several threshold and length settings; every word
// is compared against a cycle-free track model kept inside the bench
// ----------------------------------------------------------------------------
module tone_sequencer_arpeggiator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tseq_pkg::*;

    // code that no command decodes, the track stalls on it
    localparam logic [BYTE_W-1:0] CMD_STALL = CMD_REPEAT + 8'd1;
    localparam int SCRIPT_ROWS = 25;
    localparam int RANDOM_ITEMS = 550;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [BYTE_W-1:0] pitch;
        logic [BYTE_W-1:0] tone;
    } note_t;

    // one directed item; typed rows carry their own expected word
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] dat;
        bit                typed;
        bit                sounds;
        logic [BYTE_W-1:0] pitch;
        logic [BYTE_W-1:0] tone;
    } script_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              opcode;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
    logic              cfg_we;
    logic              cfg_index;
    logic [LEN_W-1:0]  cfg_data;
    logic              valid;
    logic [BYTE_W-1:0] pitch;
    logic [BYTE_W-1:0] tone;

    tone_sequencer_arpeggiator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .address   (address),
        .data      (data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .valid     (valid),
        .pitch     (pitch),
        .tone      (tone)
    );

    // ------------------------------------------------------------------
    // track model: a private copy of the store, sequencer and voice state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] track_mem [ADDR_SPAN];
    int                play_pos;
    int                repeat_mark;
    int                rest_left;
    logic [BYTE_W-1:0] beat_len;
    logic [BYTE_W-1:0] chord [PITCH_SLOTS];
    logic [PCNT_W-1:0] chord_size;
    logic [ARP_W-1:0]  arp_sel;
    logic [BYTE_W-1:0] arp_count;
    logic [BYTE_W-1:0] duty;
    bit                voice_live;
    logic [BYTE_W-1:0] hold_ticks;
    int                loop_len;

    // words still owed by the block, oldest first
    note_t notes_due [$];

    // bookkeeping
    int errors;
    int notes_checked;
    int words_written;
    int ticks_played;
    int rand_items;
    int settings_run;
    int gap_pct;

    // tune under construction
    logic [BYTE_W-1:0] tune [$];
    int                cmd_starts [$];

    script_row_t script [SCRIPT_ROWS];

    function automatic logic [BYTE_W-1:0] peek(input int off);
        return track_mem[(play_pos + off) % ADDR_SPAN];
    endfunction

    // one playback tick: sequencer first, then the voice
    task automatic play_tick(output bit sounds, output note_t n);
        int                lim;
        int                nxt;
        int                cnt;
        logic [BYTE_W-1:0] code;
        sounds = 1'b0;
        n = '0;
        if (rest_left > 0) begin
            rest_left--;
        end
        else begin
            lim = (loop_len >= 1) ? loop_len - 1 : 0;
            // wrap only applies while the length fits the store
            if (play_pos >= lim)
                play_pos = 0;
            code = peek(0);
            nxt = play_pos;
            if (code == CMD_SLEEP) begin
                rest_left = int'(peek(1)) * int'(beat_len);
                nxt = play_pos + 2;
            end
            else if (code >= CMD_PITCH_MIN && code < CMD_PITCH_MIN + PITCH_SLOTS) begin
                cnt = int'(code);
                rest_left = int'(peek(cnt + 1)) * int'(beat_len);
                for (int i = 0; i < cnt; i++)
                    chord[i] = peek(i + 1);
                chord_size = PCNT_W'(cnt);
                arp_sel = '0;
                nxt = play_pos + cnt + 2;
            end
            else if (code == CMD_TONE) begin
                duty = peek(1);
                nxt = play_pos + 2;
            end
            else if (code == CMD_VOICE) begin
                voice_live = (peek(1) != 0);
                nxt = play_pos + 2;
            end
            else if (code == CMD_RHYTHM) begin
                beat_len = peek(1);
                nxt = play_pos + 2;
            end
            else if (code == CMD_REPEAT) begin
                if (repeat_mark == play_pos) begin
                    repeat_mark = 0;
                    nxt = play_pos + 2;
                end
                else begin
                    repeat_mark = play_pos;
                    // backward jump below the start clamps to zero
                    nxt = (int'(peek(1)) > play_pos) ? 0 : play_pos - int'(peek(1));
                end
            end
            play_pos = nxt % ADDR_SPAN;
        end

        // voice: silent or empty chord leaves the arpeggio alone
        if (voice_live && chord_size != 0) begin
            if (arp_sel >= chord_size)
                arp_sel = '0;
            n.pitch = chord[arp_sel];
            n.tone = duty;
            sounds = 1'b1;
            arp_count = arp_count + 8'd1;
            if (arp_count >= hold_ticks) begin
                arp_count = '0;
                if (arp_sel + 1 < chord_size)
                    arp_sel = arp_sel + 2'd1;
                else
                    arp_sel = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driving: inputs move on the falling edge, handshakes are seen on
    // the rising edge
    // ------------------------------------------------------------------
    task automatic push_word(input logic op, input logic [ADDR_W-1:0] a,
                             input logic [BYTE_W-1:0] d, input bit typed,
                             input bit t_sounds, input note_t t_note);
        bit    snd;
        note_t nt;
        @(negedge clk);
        start = 1'b1;
        opcode = op;
        address = a;
        data = d;
        do
            @(posedge clk);
        while (busy);
        // accepted at this edge, work out what it owes
        if (op == OP_WRITE) begin
            track_mem[a] = d;
            snd = 1'b0;
            nt = '0;
            words_written++;
        end
        else begin
            play_tick(snd, nt);
            ticks_played++;
        end
        if (typed) begin
            snd = t_sounds;
            nt = t_note;
        end
        if (snd)
            notes_due.push_back(nt);
    endtask

    // sender gap with junk on the payload
    task automatic pause(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            start = 1'b0;
            opcode = 1'($urandom);
            address = ADDR_W'($urandom);
            data = BYTE_W'($urandom);
        end
    endtask

    // hold off until every owed word is out and the block is quiet
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (notes_due.size() != 0)
            @(posedge clk);
        // a silent tick may still be running
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // random-part item: optional gap, rare full drain, then the word
    task automatic send(input logic op, input logic [ADDR_W-1:0] a,
                        input logic [BYTE_W-1:0] d);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
            pause($urandom_range(1, 6));
        if ($urandom_range(299) == 0)
            drain();
        push_word(op, a, d, 1'b0, 1'b0, '0);
        rand_items++;
    endtask

    task automatic config_write(input logic idx, input logic [LEN_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_data = LEN_W'($urandom);
        if (idx == CFG_ARP_THRESHOLD)
            hold_ticks = val[BYTE_W-1:0];
        else
            loop_len = int'(val);
    endtask

    // sleep multiplier, kept short when the rhythm is long
    function automatic logic [BYTE_W-1:0] rest_byte(input logic [BYTE_W-1:0] beat);
        int r;
        r = $urandom_range(99);
        if (beat > 8)
            return BYTE_W'($urandom_range(1));
        if (r < 88)
            return BYTE_W'($urandom_range(3));
        if (r < 94)
            return 8'd255;
        return BYTE_W'($urandom);
    endfunction

    function automatic logic [BYTE_W-1:0] rhythm_byte();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return BYTE_W'($urandom_range(1, 3));
        if (r < 90)
            return 8'd0;
        if (r < 95)
            return 8'd255;
        return BYTE_W'($urandom);
    endfunction

    // build a well-formed tune of roughly the given size and write it from 0
    task automatic load_tune(input int region);
        int                r;
        int                cnt;
        int                here;
        logic [BYTE_W-1:0] beat;
        tune.delete();
        cmd_starts.delete();
        beat = rhythm_byte();
        cmd_starts.push_back(tune.size());
        tune.push_back(CMD_TONE);
        tune.push_back(BYTE_W'($urandom));
        cmd_starts.push_back(tune.size());
        tune.push_back(CMD_VOICE);
        tune.push_back(BYTE_W'($urandom_range(1, 255)));
        cmd_starts.push_back(tune.size());
        tune.push_back(CMD_RHYTHM);
        tune.push_back(beat);
        while (tune.size() < region) begin
            r = $urandom_range(99);
            here = tune.size();
            cmd_starts.push_back(here);
            if (r < 45) begin
                cnt = $urandom_range(1, PITCH_SLOTS);
                tune.push_back(BYTE_W'(cnt));
                repeat (cnt) tune.push_back(BYTE_W'($urandom));
                tune.push_back(rest_byte(beat));
            end
            else if (r < 55) begin
                tune.push_back(CMD_SLEEP);
                tune.push_back(rest_byte(beat));
            end
            else if (r < 63) begin
                tune.push_back(CMD_TONE);
                tune.push_back(BYTE_W'($urandom));
            end
            else if (r < 70) begin
                // any nonzero value turns the voice on, zero mutes it
                tune.push_back(CMD_VOICE);
                tune.push_back(($urandom_range(99) < 85) ?
                               BYTE_W'($urandom_range(1, 255)) : 8'd0);
            end
            else if (r < 77) begin
                beat = rhythm_byte();
                tune.push_back(CMD_RHYTHM);
                tune.push_back(beat);
            end
            else if (r < 90) begin
                tune.push_back(CMD_REPEAT);
                if ($urandom_range(99) < 80)
                    tune.push_back(BYTE_W'(here -
                        cmd_starts[$urandom_range(cmd_starts.size() - 1)]));
                else
                    tune.push_back(BYTE_W'($urandom));
            end
            else if (r < 91) begin
                tune.push_back(BYTE_W'($urandom_range(CMD_STALL, 255)));
            end
            else begin
                tune.push_back(CMD_SLEEP);
                tune.push_back(rest_byte(beat));
            end
        end
        // close with a jump back to the top
        tune.push_back(CMD_REPEAT);
        tune.push_back(BYTE_W'(tune.size() - 1));
        foreach (tune[i])
            send(OP_WRITE, ADDR_W'(i), tune[i]);
    endtask

    // ------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // slowest run stays well under a fifth of this
    initial begin
        #5_000_000;
        $display("tone_sequencer_arpeggiator_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // result checker: every strobed word against the oldest owed word
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        note_t owed;
        if (rst_n && valid) begin
            notes_checked++;
            if (notes_due.size() == 0) begin
                $error("unexpected word: pitch %0d tone %0d", pitch, tone);
                errors++;
            end
            else begin
                owed = notes_due.pop_front();
                if (pitch !== owed.pitch) begin
                    $error("pitch: expected %0d, got %0d", owed.pitch, pitch);
                    errors++;
                end
                if (tone !== owed.tone) begin
                    $error("tone: expected %0d, got %0d", owed.tone, tone);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [LEN_W-1:0] thr_word;
        int               thr;
        int               len;
        int               region;
        int               r;
        note_t            row_note;

        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_WRITE;
        address = '0;
        data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_ARP_THRESHOLD;
        cfg_data = '0;
        errors = 0;
        notes_checked = 0;
        words_written = 0;
        ticks_played = 0;
        rand_items = 0;
        settings_run = 0;
        gap_pct = 0;

        // model state after reset
        play_pos = 0;
        repeat_mark = 0;
        rest_left = 0;
        beat_len = RHYTHM_RESET;
        foreach (chord[i])
            chord[i] = PITCH_RESET;
        chord_size = '0;
        arp_sel = '0;
        arp_count = '0;
        duty = '0;
        voice_live = 1'b0;
        hold_ticks = THRESH_RESET;
        loop_len = int'(LEN_RESET);
        foreach (track_mem[i])
            track_mem[i] = '0;

        // tone 200, voice value above one, rhythm 1, two pitches at the
        // extremes with a one-tick sleep, a repeat back to them, then a stall
        script = '{
            '{OP_WRITE, 10'd0,    CMD_TONE,    1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd1,    8'd200,      1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd2,    CMD_VOICE,   1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd3,    8'd2,        1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd4,    CMD_RHYTHM,  1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd5,    8'd1,        1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd6,    8'd2,        1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd7,    8'd255,      1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd8,    8'd0,        1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd9,    8'd1,        1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd10,   CMD_REPEAT,  1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd11,   8'd4,        1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd12,   CMD_STALL,   1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_WRITE, 10'd1023, 8'd0,        1'b0, 1'b0, 8'd0,   8'd0},
            // tone set, voice on but no pitches yet, rhythm set: all silent
            '{OP_TICK,  10'd1023, 8'd255,      1'b1, 1'b0, 8'd0,   8'd0},
            '{OP_TICK,  10'd1023, 8'd255,      1'b1, 1'b0, 8'd0,   8'd0},
            '{OP_TICK,  10'd1023, 8'd255,      1'b1, 1'b0, 8'd0,   8'd0},
            // pitches load, first pitch sounds through the sleep and repeat
            '{OP_TICK,  10'd1023, 8'd255,      1'b1, 1'b1, 8'd255, 8'd200},
            '{OP_TICK,  10'd1023, 8'd255,      1'b1, 1'b1, 8'd255, 8'd200},
            '{OP_TICK,  10'd1023, 8'd255,      1'b1, 1'b1, 8'd255, 8'd200},
            '{OP_TICK,  10'd1023, 8'd255,      1'b1, 1'b1, 8'd255, 8'd200},
            // second pass: repeat falls through, then the stall
            '{OP_TICK,  10'd1023, 8'd255,      1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_TICK,  10'd1023, 8'd255,      1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_TICK,  10'd1023, 8'd255,      1'b0, 1'b0, 8'd0,   8'd0},
            '{OP_TICK,  10'd1023, 8'd255,      1'b0, 1'b0, 8'd0,   8'd0}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every store entry gets a known byte before any tick can read it
        for (int a = 0; a < ADDR_SPAN; a++)
            push_word(OP_WRITE, ADDR_W'(a), 8'd0, 1'b0, 1'b0, '0);

        // directed script at reset settings
        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            row_note.pitch = script[i].pitch;
            row_note.tone = script[i].tone;
            push_word(script[i].op, script[i].addr, script[i].dat,
                      script[i].typed, script[i].sounds, row_note);
        end

        // random phases: new settings, a fresh tune, then mostly ticks
        while (rand_items < RANDOM_ITEMS) begin
            case (settings_run)
                0: begin thr = 1;   len = 2;    end
                1: begin thr = 255; len = 1024; end
                2: begin thr = 0;   len = 1;    end
                3: begin thr = 3;   len = 0;    end
                4: begin thr = 2;   len = 2047; end
                default: begin
                    thr = ($urandom_range(99) < 70) ? $urandom_range(1, 6) :
                                                      $urandom_range(1, 255);
                    r = $urandom_range(99);
                    len = (r < 80) ? $urandom_range(3, 40) : (r < 90) ? 2 : 1024;
                end
            endcase
            // settings only change with the block quiet
            drain();
            // upper bits of the threshold word are don't-care
            thr_word = LEN_W'($urandom);
            thr_word[BYTE_W-1:0] = BYTE_W'(thr);
            config_write(CFG_ARP_THRESHOLD, thr_word);
            config_write(CFG_SEQ_LENGTH, LEN_W'(len));

            // idling rotates: none, sender busy-ish, sender light
            case (settings_run % 3)
                0: gap_pct = 0;
                1: gap_pct = 47;
                default: gap_pct = 23;
            endcase

            region = (len >= 2 && len <= 58) ? len + 6 : (len < 2) ? 8 : 48;
            load_tune(region);

            repeat (110) begin
                r = $urandom_range(99);
                if (r < 6)
                    // edit inside the tune with a plausible byte
                    send(OP_WRITE, ADDR_W'($urandom_range(region - 1)),
                         ($urandom_range(1) == 0) ? BYTE_W'($urandom_range(CMD_REPEAT))
                                                  : BYTE_W'($urandom));
                else if (r < 8)
                    send(OP_WRITE, ADDR_W'($urandom), BYTE_W'($urandom));
                else
                    send(OP_TICK, ADDR_W'($urandom), BYTE_W'($urandom));
            end
            settings_run++;
        end

        // wind down: everything owed, then room for stray words
        @(negedge clk);
        start = 1'b0;
        while (notes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d store writes and %0d ticks over %0d settings,",
                 words_written, ticks_played, settings_run);
        $display("with %0d pitch/tone words compared", notes_checked);
        if (errors == 0)
            $display("tone_sequencer_arpeggiator_test: done, clean");
        else
            $display("tone_sequencer_arpeggiator_test: done, errors");
        $finish;
    end

endmodule
